// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define LPMR_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked in every cycle, reset included.
`define LPMR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lpmr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmr_pkg
// Constants, status codes and the queued item type shared by the message ring.
// ----------------------------------------------------------------------------
`default_nettype none

package lpmr_pkg;

  // Ring size in bytes. Offsets count modulo twice this value, so it is a
  // power of two and offsets wrap naturally in OFF_W bits.
  localparam int RING_BYTES = 32768;
  localparam int RING_WORDS = RING_BYTES / 4;
  localparam int OFF_W      = $clog2(2 * RING_BYTES);
  localparam int WADDR_W    = $clog2(RING_WORDS);
  localparam int LANES      = 4;
  localparam int HDR_BYTES  = 4;

  localparam int LEN_W  = 15;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_MISMATCH = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_TOO_LONG = 3'd4
  } status_t;

  typedef struct packed {
    logic              is_get;
    logic [LEN_W-1:0]  msg_len;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    logic [LEN_W-1:0]  max_len;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

`default_nettype wire

// ===== hdl/lpmr_ram.sv =====
// ----------------------------------------------------------------------------
// lpmr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/lpmr_front.sv =====
// ----------------------------------------------------------------------------
// lpmr_front
// Accepts put and get transactions, classifies them and queues them for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          func,
  input  logic [lpmr_pkg::LEN_W-1:0]    msg_len,
  input  logic [lpmr_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          last,
  input  logic [lpmr_pkg::LEN_W-1:0]    max_len,
  output logic                          busy,
  output lpmr_pkg::queue_head_t         head,
  input  logic                          pop
);
  import lpmr_pkg::*;

  item_t             entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  item_t             new_item;

  assign busy = (count == (QPTR_W+1)'(QDEPTH));
  assign push = start && !busy;

  always_comb begin
    new_item.is_get    = func;
    new_item.msg_len   = msg_len;
    new_item.data_byte = data_byte;
    new_item.last      = last;
    new_item.max_len   = max_len;
  end

  assign head.valid = (count != '0);
  assign head.item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= new_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lpmr_back.sv =====
// ----------------------------------------------------------------------------
// lpmr_back
// Carries out queued put and get transactions against the byte ring and
// registers one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  lpmr_pkg::queue_head_t         head,
  output logic                          pop,
  output logic                          done,
  output logic [lpmr_pkg::STAT_W-1:0]   status,
  output logic [lpmr_pkg::BYTE_W-1:0]   data_byte_res,
  output logic [lpmr_pkg::LEN_W-1:0]    msg_len_res,
  output logic                          last_res
);
  import lpmr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_PUT_BYTE = 4'b0010,
    ST_HDR      = 4'b0100,
    ST_BYTE     = 4'b1000
  } back_state_t;

  typedef enum logic [3:0] {
    PM_IDLE    = 4'b0001,
    PM_ACTIVE  = 4'b0010,
    PM_FULL    = 4'b0100,
    PM_DISCARD = 4'b1000
  } put_mode_t;

  back_state_t      state, state_next;
  put_mode_t        put_mode, put_mode_next;
  item_t            cur, cur_next;
  logic [OFF_W-1:0] pending_off, pending_off_next;
  logic [OFF_W-1:0] committed_off, committed_off_next;
  logic [OFF_W-1:0] read_off, read_off_next;
  logic [OFF_W-1:0] get_ptr, get_ptr_next;
  logic [LEN_W-1:0] put_rem, put_rem_next;
  logic [LEN_W-1:0] put_len, put_len_next;
  logic [LEN_W-1:0] get_rem, get_rem_next;
  logic [LEN_W-1:0] get_len, get_len_next;
  logic             get_active, get_active_next;

  logic              done_next;
  status_t           status_next;
  logic [BYTE_W-1:0] byte_next;
  logic [LEN_W-1:0]  len_next;
  logic              last_next;

  logic              ram_we [LANES];
  logic [BYTE_W-1:0] ram_wdata [LANES];
  logic [BYTE_W-1:0] ram_rdata [LANES];
  logic [WADDR_W-1:0] ram_waddr;
  logic [WADDR_W-1:0] ram_raddr;

  function automatic logic [OFF_W-1:0] off_align(input logic [OFF_W-1:0] v);
    logic [OFF_W-1:0] s;
    s = v + OFF_W'(3);
    return {s[OFF_W-1:2], 2'b00};
  endfunction

  function automatic logic [WADDR_W-1:0] word_of(input logic [OFF_W-1:0] v);
    return v[WADDR_W+1:2];
  endfunction

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lpmr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_WORDS)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .waddr (ram_waddr),
      .wdata (ram_wdata[g]),
      .raddr (ram_raddr),
      .rdata (ram_rdata[g])
    );
  end

  always_comb begin
    logic [OFF_W-1:0]          wa;
    logic [OFF_W-1:0]          ra;
    logic [OFF_W-1:0]          used_p;
    logic [OFF_W-1:0]          used_g;
    logic [OFF_W+1:0]          need;
    logic [LANES*BYTE_W-1:0]   hdr_word;
    logic [LEN_W-1:0]          mlen;
    logic [LEN_W-1:0]          rem_after;
    logic [OFF_W-1:0]          pend_after;
    item_t                     it;

    state_next         = state;
    put_mode_next      = put_mode;
    cur_next           = cur;
    pending_off_next   = pending_off;
    committed_off_next = committed_off;
    read_off_next      = read_off;
    get_ptr_next       = get_ptr;
    put_rem_next       = put_rem;
    put_len_next       = put_len;
    get_rem_next       = get_rem;
    get_len_next       = get_len;
    get_active_next    = get_active;

    pop         = 1'b0;
    done_next   = 1'b0;
    status_next = STAT_OK;
    byte_next   = '0;
    len_next    = '0;
    last_next   = 1'b0;

    ram_waddr = word_of(pending_off);
    ram_raddr = word_of(get_ptr);
    for (int i = 0; i < LANES; i++) begin
      ram_we[i]    = 1'b0;
      ram_wdata[i] = cur.data_byte;
    end

    it         = head.item;
    wa         = off_align(committed_off);
    ra         = off_align(read_off);
    used_p     = wa - read_off;
    used_g     = committed_off - ra;
    need       = (OFF_W+2)'(used_p) + (OFF_W+2)'(HDR_BYTES) + (OFF_W+2)'(it.msg_len);
    hdr_word   = (LANES*BYTE_W)'(it.msg_len);
    mlen       = LEN_W'({ram_rdata[1], ram_rdata[0]});
    rem_after  = put_rem - 1'b1;
    pend_after = pending_off + 1'b1;

    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop      = 1'b1;
          cur_next = it;
          if (!it.is_get) begin
            case (put_mode)
              PM_IDLE: begin
                put_len_next = it.msg_len;
                if (need > (OFF_W+2)'(RING_BYTES)) begin
                  put_mode_next = it.last ? PM_IDLE : PM_FULL;
                  done_next     = 1'b1;
                  status_next   = STAT_FULL;
                end else begin
                  ram_waddr = word_of(wa);
                  for (int i = 0; i < LANES; i++) begin
                    ram_we[i]    = 1'b1;
                    ram_wdata[i] = hdr_word[i*BYTE_W +: BYTE_W];
                  end
                  pending_off_next = wa + OFF_W'(HDR_BYTES);
                  put_rem_next     = it.msg_len;
                  if (it.msg_len != '0) begin
                    // The first body byte needs the write port next cycle.
                    state_next = ST_PUT_BYTE;
                  end else begin
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    if (it.last) begin
                      put_mode_next      = PM_IDLE;
                      committed_off_next = wa + OFF_W'(HDR_BYTES);
                    end else begin
                      put_mode_next = PM_ACTIVE;
                    end
                  end
                end
              end
              PM_ACTIVE: begin
                done_next = 1'b1;
                if (put_rem == '0) begin
                  put_mode_next = it.last ? PM_IDLE : PM_DISCARD;
                  status_next   = STAT_MISMATCH;
                end else begin
                  ram_waddr                    = word_of(pending_off);
                  ram_we[pending_off[1:0]]     = 1'b1;
                  for (int i = 0; i < LANES; i++) begin
                    ram_wdata[i] = it.data_byte;
                  end
                  pending_off_next = pend_after;
                  put_rem_next     = rem_after;
                  if (!it.last) begin
                    put_mode_next = PM_ACTIVE;
                    status_next   = STAT_OK;
                  end else begin
                    put_mode_next = PM_IDLE;
                    if (rem_after == '0) begin
                      committed_off_next = pend_after;
                      status_next        = STAT_OK;
                    end else begin
                      status_next = STAT_MISMATCH;
                    end
                  end
                end
              end
              PM_FULL: begin
                done_next   = 1'b1;
                status_next = STAT_FULL;
                if (it.last) begin
                  put_mode_next = PM_IDLE;
                end
              end
              default: begin
                done_next   = 1'b1;
                status_next = STAT_MISMATCH;
                if (it.last) begin
                  put_mode_next = PM_IDLE;
                end
              end
            endcase
            len_next = put_len_next;
          end else begin
            if (get_active && get_rem != '0) begin
              ram_raddr  = word_of(get_ptr);
              state_next = ST_BYTE;
            end else begin
              get_active_next = 1'b0;
              if (used_g == '0 || used_g > OFF_W'(RING_BYTES)) begin
                done_next   = 1'b1;
                status_next = STAT_EMPTY;
              end else begin
                ram_raddr    = word_of(ra);
                get_ptr_next = ra + OFF_W'(HDR_BYTES);
                state_next   = ST_HDR;
              end
            end
          end
        end
      end
      ST_PUT_BYTE: begin
        ram_waddr                = word_of(pending_off);
        ram_we[pending_off[1:0]] = 1'b1;
        pending_off_next         = pend_after;
        put_rem_next             = rem_after;
        done_next                = 1'b1;
        len_next                 = put_len;
        state_next               = ST_IDLE;
        if (!cur.last) begin
          put_mode_next = PM_ACTIVE;
          status_next   = STAT_OK;
        end else begin
          put_mode_next = PM_IDLE;
          if (rem_after == '0) begin
            committed_off_next = pend_after;
            status_next        = STAT_OK;
          end else begin
            status_next = STAT_MISMATCH;
          end
        end
      end
      ST_HDR: begin
        if (mlen > cur.max_len) begin
          done_next   = 1'b1;
          status_next = STAT_TOO_LONG;
          len_next    = mlen;
          state_next  = ST_IDLE;
        end else begin
          get_len_next = mlen;
          if (mlen == '0) begin
            read_off_next = get_ptr;
            done_next     = 1'b1;
            status_next   = STAT_OK;
            last_next     = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            get_rem_next    = mlen;
            get_active_next = 1'b1;
            ram_raddr       = word_of(get_ptr);
            state_next      = ST_BYTE;
          end
        end
      end
      ST_BYTE: begin
        done_next    = 1'b1;
        status_next  = STAT_OK;
        byte_next    = ram_rdata[get_ptr[1:0]];
        len_next     = get_len;
        get_ptr_next = get_ptr + 1'b1;
        get_rem_next = get_rem - 1'b1;
        if (get_rem == LEN_W'(1)) begin
          // Final byte: the whole message is consumed now.
          get_active_next = 1'b0;
          read_off_next   = get_ptr + 1'b1;
          last_next       = 1'b1;
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      put_mode      <= PM_IDLE;
      pending_off   <= '0;
      committed_off <= '0;
      read_off      <= '0;
      get_ptr       <= '0;
      put_rem       <= '0;
      put_len       <= '0;
      get_rem       <= '0;
      get_len       <= '0;
      get_active    <= 1'b0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      put_mode      <= put_mode_next;
      pending_off   <= pending_off_next;
      committed_off <= committed_off_next;
      read_off      <= read_off_next;
      get_ptr       <= get_ptr_next;
      put_rem       <= put_rem_next;
      put_len       <= put_len_next;
      get_rem       <= get_rem_next;
      get_len       <= get_len_next;
      get_active    <= get_active_next;
      done          <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur           <= cur_next;
    status        <= status_next;
    data_byte_res <= byte_next;
    msg_len_res   <= len_next;
    last_res      <= last_next;
  end

endmodule

`default_nettype wire

// ===== hdl/length_prefixed_message_ring_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_core
// Byte ring of length-prefixed messages with byte-wide put and get.
//
//   Channel   Handshake             Signals
//   -------   -------------------   --------------------------------------------
//   request   start && !busy        func, msg_len, data_byte, last, max_len
//   result    done (one cycle)      status, data_byte_res, msg_len_res, last_res
//
// A transaction reaches the back end in the cycle after it is accepted, or later
// while earlier transactions hold the back end. A put byte is written from the
// idle state; the first byte of a message also passes through ST_PUT_BYTE (header
// and byte share the ring write port); a get byte passes through ST_BYTE
// (registered ring read); and a get at a message start passes through ST_HDR,
// then ST_BYTE (header read, then byte read). The result register follows the
// last of these states and raises done. busy is high while the queue is full; the
// receiver cannot stall. Reset clears all offsets and modes; the ring contents
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_message_ring_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [lpmr_pkg::LEN_W-1:0]    msg_len,
  input  logic [lpmr_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          last,
  input  logic [lpmr_pkg::LEN_W-1:0]    max_len,
  output logic                          done,
  output logic [lpmr_pkg::STAT_W-1:0]   status,
  output logic [lpmr_pkg::BYTE_W-1:0]   data_byte_res,
  output logic [lpmr_pkg::LEN_W-1:0]    msg_len_res,
  output logic                          last_res
);
  import lpmr_pkg::*;

  queue_head_t head;
  logic        pop;

  lpmr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .msg_len   (msg_len),
    .data_byte (data_byte),
    .last      (last),
    .max_len   (max_len),
    .busy      (busy),
    .head      (head),
    .pop       (pop)
  );

  lpmr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .done          (done),
    .status        (status),
    .data_byte_res (data_byte_res),
    .msg_len_res   (msg_len_res),
    .last_res      (last_res)
  );

endmodule

`default_nettype wire

// ===== hdl/lpmr_checker.sv =====
// ----------------------------------------------------------------------------
// lpmr_checker
// Port-level checks on the results of the message ring, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lpmr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [lpmr_pkg::STAT_W-1:0]   status,
  input logic [lpmr_pkg::BYTE_W-1:0]   data_byte_res,
  input logic [lpmr_pkg::LEN_W-1:0]    msg_len_res,
  input logic                          last_res
);
  import lpmr_pkg::*;

  logic accepted;

  assign accepted = start && !busy;

  // Only a successful get delivers a byte or marks the end of a message.
  `LPMR_ASSERT_RST(a_fail_no_data, clk, rst, (done && status != STAT_OK) |-> (data_byte_res == '0 && !last_res), "failed transaction carries data")
  // An empty ring reports no length.
  `LPMR_ASSERT_RST(a_empty_no_len, clk, rst, (done && status == STAT_EMPTY) |-> (msg_len_res == '0), "empty result with a length")
  // No result may appear right after reset.
  `LPMR_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !done, "result right after reset")
  // A result never appears in the cycle right after an acceptance in the first cycle out of reset.
  `LPMR_ASSERT_ALWAYS(a_no_early_result, clk, ($past(rst) && accepted) |=> !done, "result too early")

endmodule

bind length_prefixed_message_ring_core lpmr_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .data_byte_res (data_byte_res),
  .msg_len_res   (msg_len_res),
  .last_res      (last_res)
);

`default_nettype wire
